### rtl/core/pidpdc_pkg.sv
// ----------------------------------------------------------------------------
// pidpdc_pkg
// Shared types, constants and helper functions of the PID drive controller.
// ----------------------------------------------------------------------------
package pidpdc_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS  = 16;   // fraction bits of gains and internal values
  localparam int GAMMA_BITS = 16;   // fraction bits of the derivative filter weight
  localparam logic [GAMMA_BITS:0] GAMMA_ONE = (GAMMA_BITS+1)'(1) << GAMMA_BITS;

  // Field and state widths.
  localparam int IO_W      = 16;
  localparam int GAIN_W    = 24;
  localparam int GAMMA_W   = GAMMA_BITS + 1;
  localparam int LIMIT_W   = 15;
  localparam int SEP_W     = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF1_W   = 18;
  localparam int DIFF2_W   = 19;
  localparam int STATE_W   = 48;
  localparam int DERIV_W   = 44;
  localparam int MUL_A_W   = 44;
  localparam int MUL_B_W   = 19;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 64;
  localparam int STEP_W    = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MODE, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
    REG_DERIV_FILTER, REG_INTEGRAL_LIMIT, REG_OUTPUT_LIMIT, REG_SEPARATION
  } reg_idx_t;

  typedef enum logic {
    MODE_POSITION = 1'b0,
    MODE_DELTA    = 1'b1
  } pid_mode_t;

  typedef enum logic [2:0] {
    MA_GAIN_P, MA_GAIN_I, MA_GAIN_D, MA_PROD, MA_LAST_D
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_ERR, MB_DIFF1, MB_DIFF2, MB_GAMMA_C, MB_GAMMA
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,          // keep the accumulator
    ACC_LD_INTEG,      // load the integral
    ACC_LD_RUN,        // load the running output
    ACC_LD_PROD,       // load the product register
    ACC_ADD_PROD,      // add the product register
    ACC_ADD_INTEG_SEP, // add the integral unless the error is too large
    ACC_DERIV,         // drop the gamma fraction bits, store as the last derivative
    ACC_CLAMP_OUT      // clamp to the output limit
  } acc_op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_EMIT
  } seq_state_t;

  typedef struct packed {
    mul_a_sel_t a_sel;
    mul_b_sel_t b_sel;
    acc_op_t    acc_op;
    logic       integ_wr;
    logic       last;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic load;
    logic emit;
  } dp_ctrl_t;

  typedef struct packed {
    pid_mode_t           mode;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [GAMMA_W-1:0]  deriv_filter;
    logic [LIMIT_W-1:0]  integral_limit;
    logic [LIMIT_W-1:0]  output_limit;
    logic [SEP_W-1:0]    separation_threshold;
  } cfg_t;

  localparam uop_t UOP_IDLE = '{a_sel: MA_GAIN_P, b_sel: MB_ERR, acc_op: ACC_HOLD,
                                integ_wr: 1'b0, last: 1'b0};

  // Micro-program of both control laws. Each step may start one product
  // and apply one accumulator operation to the product of the step before.
  function automatic uop_t uop_lookup(input pid_mode_t mode,
                                      input logic [STEP_W-1:0] step);
    uop_t u;
    u = UOP_IDLE;
    if (mode == MODE_POSITION) begin
      unique case (step)
        4'd0: begin
          u.a_sel = MA_GAIN_I; u.b_sel = MB_ERR; u.acc_op = ACC_LD_INTEG;
        end
        4'd1: begin
          u.a_sel = MA_GAIN_D; u.b_sel = MB_DIFF1; u.acc_op = ACC_ADD_PROD;
        end
        4'd2: begin
          u.a_sel = MA_PROD; u.b_sel = MB_GAMMA_C; u.integ_wr = 1'b1;
        end
        4'd3: begin
          u.a_sel = MA_LAST_D; u.b_sel = MB_GAMMA; u.acc_op = ACC_LD_PROD;
        end
        4'd4: u.acc_op = ACC_ADD_PROD;
        4'd5: begin
          u.a_sel = MA_GAIN_P; u.b_sel = MB_ERR; u.acc_op = ACC_DERIV;
        end
        4'd6: u.acc_op = ACC_ADD_PROD;
        4'd7: u.acc_op = ACC_ADD_INTEG_SEP;
        4'd8: begin
          u.acc_op = ACC_CLAMP_OUT; u.last = 1'b1;
        end
        default: u.last = 1'b1;
      endcase
    end else begin
      unique case (step)
        4'd0: begin
          u.a_sel = MA_GAIN_P; u.b_sel = MB_DIFF1; u.acc_op = ACC_LD_RUN;
        end
        4'd1: begin
          u.a_sel = MA_GAIN_I; u.b_sel = MB_ERR; u.acc_op = ACC_ADD_PROD;
        end
        4'd2: begin
          u.a_sel = MA_GAIN_D; u.b_sel = MB_DIFF2; u.acc_op = ACC_ADD_PROD;
        end
        4'd3: u.acc_op = ACC_ADD_PROD;
        4'd4: begin
          u.acc_op = ACC_CLAMP_OUT; u.last = 1'b1;
        end
        default: u.last = 1'b1;
      endcase
    end
    return u;
  endfunction

  // Symmetric saturation to plus or minus a non-negative limit.
  function automatic logic signed [ACC_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] x,
                                                        input logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

### rtl/core/pidpdc_regs.sv
// ----------------------------------------------------------------------------
// pidpdc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module pidpdc_regs
  import pidpdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:           cfg_nxt.mode = pid_mode_t'(pwdata[0]);
        REG_GAIN_P:         cfg_nxt.gain_p = pwdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i = pwdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d = pwdata[GAIN_W-1:0];
        REG_DERIV_FILTER:   cfg_nxt.deriv_filter = pwdata[GAMMA_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = pwdata[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_nxt.output_limit = pwdata[LIMIT_W-1:0];
        REG_SEPARATION:     cfg_nxt.separation_threshold = pwdata[SEP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:           prdata = CFG_DATA_W'(cfg_r.mode);
      REG_GAIN_P:         prdata = CFG_DATA_W'(cfg_r.gain_p);
      REG_GAIN_I:         prdata = CFG_DATA_W'(cfg_r.gain_i);
      REG_GAIN_D:         prdata = CFG_DATA_W'(cfg_r.gain_d);
      REG_DERIV_FILTER:   prdata = CFG_DATA_W'(cfg_r.deriv_filter);
      REG_INTEGRAL_LIMIT: prdata = CFG_DATA_W'(cfg_r.integral_limit);
      REG_OUTPUT_LIMIT:   prdata = CFG_DATA_W'(cfg_r.output_limit);
      REG_SEPARATION:     prdata = CFG_DATA_W'(cfg_r.separation_threshold);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode                 <= MODE_POSITION;
      cfg_r.gain_p               <= '0;
      cfg_r.gain_i               <= '0;
      cfg_r.gain_d               <= '0;
      cfg_r.deriv_filter         <= '0;
      cfg_r.integral_limit       <= '1;
      cfg_r.output_limit         <= '1;
      cfg_r.separation_threshold <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/pidpdc_sequencer.sv
// ----------------------------------------------------------------------------
// pidpdc_sequencer
// Handshake control and micro-program step counter for the shared datapath.
// ----------------------------------------------------------------------------
module pidpdc_sequencer
  import pidpdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pid_mode_t mode,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output dp_ctrl_t  ctrl
);

  seq_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;
  uop_t               uop;

  assign uop        = uop_lookup(mode, step_r);
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        step_nxt = step_r + STEP_W'(1);
        if (uop.last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = 1'b0;
    ctrl.uop  = UOP_IDLE;
    ctrl.emit = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RUN:  ctrl.uop = uop;
      ST_EMIT: ctrl.emit = slot_free;
      default: ;
    endcase
    ctrl.load = in_tready & in_tvalid;
  end

  always_comb begin
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/pidpdc_datapath.sv
// ----------------------------------------------------------------------------
// pidpdc_datapath
// Shared multiplier, accumulator and controller state of the PID block.
// ----------------------------------------------------------------------------
module pidpdc_datapath
  import pidpdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  dp_ctrl_t               ctrl,
  input  logic signed [IO_W-1:0] setpoint,
  input  logic signed [IO_W-1:0] feedback,
  output logic signed [IO_W-1:0] drive
);

  // Controller state.
  logic signed [ERR_W-1:0]   err_prev_r, err_prev_nxt;
  logic signed [ERR_W-1:0]   err_prev2_r, err_prev2_nxt;
  logic signed [STATE_W-1:0] integ_r, integ_nxt;
  logic signed [DERIV_W-1:0] last_d_r, last_d_nxt;
  logic signed [STATE_W-1:0] run_out_r, run_out_nxt;

  // Working registers of one sample.
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DIFF1_W-1:0] diff1_r;
  logic signed [DIFF2_W-1:0] diff2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [IO_W-1:0]    drive_r;

  logic signed [ERR_W-1:0]   err_in;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic [GAMMA_W-1:0]        gamma, gamma_c;
  logic [ERR_W-1:0]          err_mag;
  logic                      sep_ok;
  logic signed [ACC_W-1:0]   prod_ext, integ_ext, acc_shift;
  logic signed [ACC_W-1:0]   ilim, olim, round_sum;

  assign err_in = ERR_W'(setpoint) - ERR_W'(feedback);

  // Filter weight saturates at one.
  assign gamma   = (cfg.deriv_filter > GAMMA_ONE) ? GAMMA_ONE : cfg.deriv_filter;
  assign gamma_c = GAMMA_ONE - gamma;

  assign err_mag = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign sep_ok  = err_mag <= {1'b0, cfg.separation_threshold};

  assign ilim = $signed({{(ACC_W-LIMIT_W){1'b0}}, cfg.integral_limit}) <<< FRAC_BITS;
  assign olim = $signed({{(ACC_W-LIMIT_W){1'b0}}, cfg.output_limit}) <<< FRAC_BITS;

  assign prod_ext  = ACC_W'(prod_r);
  assign integ_ext = ACC_W'(integ_r);
  assign acc_shift = acc_r >>> GAMMA_BITS;

  // Operand selection for the one shared multiplier.
  always_comb begin
    unique case (ctrl.uop.a_sel)
      MA_GAIN_P: mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain_p});
      MA_GAIN_I: mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain_i});
      MA_GAIN_D: mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain_d});
      MA_PROD:   mul_a = prod_r[MUL_A_W-1:0];
      MA_LAST_D: mul_a = MUL_A_W'(last_d_r);
      default:   mul_a = '0;
    endcase
    unique case (ctrl.uop.b_sel)
      MB_ERR:     mul_b = MUL_B_W'(err_r);
      MB_DIFF1:   mul_b = MUL_B_W'(diff1_r);
      MB_DIFF2:   mul_b = diff2_r;
      MB_GAMMA_C: mul_b = $signed({{(MUL_B_W-GAMMA_W){1'b0}}, gamma_c});
      MB_GAMMA:   mul_b = $signed({{(MUL_B_W-GAMMA_W){1'b0}}, gamma});
      default:    mul_b = '0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    unique case (ctrl.uop.acc_op)
      ACC_HOLD:          acc_nxt = acc_r;
      ACC_LD_INTEG:      acc_nxt = integ_ext;
      ACC_LD_RUN:        acc_nxt = ACC_W'(run_out_r);
      ACC_LD_PROD:       acc_nxt = prod_ext;
      ACC_ADD_PROD:      acc_nxt = acc_r + prod_ext;
      ACC_ADD_INTEG_SEP: acc_nxt = sep_ok ? acc_r + integ_ext : acc_r;
      ACC_DERIV:         acc_nxt = acc_shift;
      ACC_CLAMP_OUT:     acc_nxt = clamp_sym(acc_r, olim);
      default:           acc_nxt = acc_r;
    endcase
  end

  // Truncation toward zero: negative values are biased up before the shift.
  assign round_sum = acc_r + (acc_r[ACC_W-1] ? ACC_W'((64'd1 << FRAC_BITS) - 64'd1) : '0);

  always_comb begin
    integ_nxt     = integ_r;
    last_d_nxt    = last_d_r;
    run_out_nxt   = run_out_r;
    err_prev_nxt  = err_prev_r;
    err_prev2_nxt = err_prev2_r;
    if (ctrl.uop.integ_wr) begin
      integ_nxt = STATE_W'(clamp_sym(acc_r, ilim));
    end
    if (ctrl.uop.acc_op == ACC_DERIV) begin
      last_d_nxt = acc_shift[DERIV_W-1:0];
    end
    if (ctrl.emit) begin
      run_out_nxt   = acc_r[STATE_W-1:0];
      err_prev_nxt  = err_r;
      err_prev2_nxt = err_prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_prev_r  <= '0;
      err_prev2_r <= '0;
      integ_r     <= '0;
      last_d_r    <= '0;
      run_out_r   <= '0;
    end else begin
      err_prev_r  <= err_prev_nxt;
      err_prev2_r <= err_prev2_nxt;
      integ_r     <= integ_nxt;
      last_d_r    <= last_d_nxt;
      run_out_r   <= run_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctrl.load) begin
      err_r   <= err_in;
      diff1_r <= DIFF1_W'(err_in) - DIFF1_W'(err_prev_r);
      diff2_r <= DIFF2_W'(err_in) - (DIFF2_W'(err_prev_r) <<< 1) + DIFF2_W'(err_prev2_r);
    end
    if (ctrl.emit) begin
      drive_r <= IO_W'(round_sum >>> FRAC_BITS);
    end
  end

  assign drive = drive_r;

endmodule

### rtl/core/pid_position_delta_controller_unit.sv
// ----------------------------------------------------------------------------
// pid_position_delta_controller_unit
// PID drive controller, positional or incremental, with integral separation.
// ----------------------------------------------------------------------------
// Each input beat carries a setpoint and a feedback sample and yields exactly
// one output beat with the clamped drive value. One sample is processed at a
// time: after a beat is taken, in_tready stays low until its drive value
// has been moved into the output register, because every product goes
// through the single shared 44 x 19 bit multiplier, one per cycle, under a
// short micro-program. A finished drive value sits in the output register,
// so the next sample may be taken while that beat still waits; if the
// previous beat has not been taken when the next one is ready, the block
// holds until it has. Registers are to be written through the APB-style port
// only while no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pid_position_delta_controller_unit
  import pidpdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,    // [15:0] setpoint, [31:16] feedback
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,   // [15:0] drive
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                   cfg;
  dp_ctrl_t               ctrl;
  logic signed [IO_W-1:0] drive;

  // Register file: mode, gains, filter weight, limits and threshold.
  pidpdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // The sequencer steps through the micro-program of the selected mode and
  // owns both handshakes, including the valid flag of the output register.
  pidpdc_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (cfg.mode),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  // The datapath holds the error history, the integral, the last filtered
  // derivative and the running output, and the drive value of the output
  // register.
  pidpdc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ctrl     (ctrl),
    .setpoint (in_tdata[15:0]),
    .feedback (in_tdata[31:16]),
    .drive    (drive)
  );

  assign out_tdata = drive;

endmodule

### rtl/core/pidpdc_checker.sv
// ----------------------------------------------------------------------------
// pidpdc_checker
// Port-level assertions for the PID drive controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidpdc_checker
  import pidpdc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Only one sample is in flight: a taken beat closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while a sample is in flight");

  // No result can appear in the cycle straight after an input beat.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too soon after an input beat");

  // Reset leaves the block open for input with no result pending.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind pid_position_delta_controller_unit pidpdc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the positional and incremental PID controller.
// ----------------------------------------------------------------------------
// Samples go in as beats on the input stream and every sample must come back
// as exactly one drive beat. A behavioural copy of the control law runs next
// to the block. It keeps its own error history, integral, filtered derivative
// and running output, and its own copy of the registers. Every drive beat is
// compared with the oldest value that is still due.
// A short table of directed steps comes first: register writes, extremes of
// the error and the gains, integral clamping and separation, gamma above one,
// and switches between the two modes. A long random part follows, in phases.
// Each phase loads a fresh register set while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import pidpdc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE       = 12;    // covers the time a positional sample keeps the block busy
  localparam int PLAN_ROWS    = 40;
  localparam int LONG_HOLD    = 300;

  // One row of the directed table: either a register write or one sample,
  // with a drive value typed in where it is obvious.
  typedef struct {
    bit          is_write;
    reg_idx_t    idx;
    logic [31:0] val;
    logic [15:0] sp;
    logic [15:0] fb;
    bit          lit_on;
    logic [15:0] lit;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;      // [15:0] setpoint, [31:16] feedback
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;          // [15:0] drive
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Register copy and state of the behavioural controller.
  cfg_t   ctl;
  longint err_last, err_last2, integ_sum, deriv_last, drive_fx;

  logic [15:0] drives_due [$];   // drive values still to come, oldest first
  logic [16:0] literal_q [$];    // per sample: typed-in value flag and value

  int  mismatches = 0;
  int  cycle_count = 0;
  int  sink_hold = 0;            // long receiver hold-off, in cycles
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  calm = 1'b0;              // no idling on either side

  plan_row_t plan [PLAN_ROWS];

  pid_position_delta_controller_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Run limit. A correct run needs well under a tenth of it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("pid_position_delta_controller_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Behavioural controller
  // --------------------------------------------------------------------------

  function automatic longint sat_sym(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Advances the controller by one sample and returns the drive value.
  // All products stay well inside 64 bits: the largest is the unfiltered
  // derivative term, below 2^58.
  function automatic logic [15:0] control_step(input logic [15:0] sp, input logic [15:0] fb);
    longint err, kp, ki, kd, g, ilim, olim, sum, mag, d, drive;
    err  = longint'($signed(sp)) - longint'($signed(fb));
    kp   = longint'(ctl.gain_p);
    ki   = longint'(ctl.gain_i);
    kd   = longint'(ctl.gain_d);
    olim = longint'(ctl.output_limit) <<< FRAC_BITS;
    if (ctl.mode == MODE_POSITION) begin
      // Gamma above one behaves as exactly one.
      g    = (ctl.deriv_filter > GAMMA_ONE) ? longint'(GAMMA_ONE) : longint'(ctl.deriv_filter);
      ilim = longint'(ctl.integral_limit) <<< FRAC_BITS;
      // A lowered limit takes hold here, on the next positional sample.
      integ_sum  = sat_sym(integ_sum + ki * err, ilim);
      d          = (kd * (err - err_last) * (longint'(GAMMA_ONE) - g) + g * deriv_last)
                   >>> GAMMA_BITS;
      deriv_last = d;
      sum        = kp * err + d;
      mag        = (err < 0) ? -err : err;
      if (mag <= longint'(ctl.separation_threshold)) begin
        sum += integ_sum;
      end
    end else begin
      // Incremental law; the positional integral and derivative are left alone.
      sum = drive_fx + kp * (err - err_last) + ki * err
            + kd * (err - 2 * err_last + err_last2);
    end
    sum       = sat_sym(sum, olim);
    drive_fx  = sum;
    err_last2 = err_last;
    err_last  = err;
    // The integer part is truncated toward zero, not floored.
    drive = (sum < 0) ? -((-sum) >>> FRAC_BITS) : (sum >>> FRAC_BITS);
    return drive[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 100) begin
      $display("MISMATCH at cycle %0d, %s: got %0d, expected %0d",
               cycle_count, what, $signed(got), $signed(want));
    end
    mismatches++;
  endtask

  // An accepted input beat queues its drive value; an accepted output beat
  // is compared with the oldest queued one. Samples from the directed table
  // with a typed-in value are checked against that value, but the
  // behavioural controller still steps so that its state keeps in line.
  always @(posedge clk) begin : scoreboard
    logic [15:0] want;
    logic [16:0] lit;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = control_step(in_tdata[15:0], in_tdata[31:16]);
        lit  = (literal_q.size() != 0) ? literal_q.pop_front() : '0;
        drives_due.push_back(lit[16] ? lit[15:0] : want);
      end
      if (out_tvalid && out_tready) begin
        if (drives_due.size() == 0) begin
          report_mismatch("drive beat with no sample pending", out_tdata, '0);
        end else begin
          want = drives_due.pop_front();
          if (out_tdata !== want) begin
            report_mismatch("drive", out_tdata, want);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: short random stalls, plus one long hold-off on request
  // during which the sender keeps offering beats until the block backs up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else if (burst > 0) begin
        out_tready <= 1'b0;
        burst--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        burst = $urandom_range(1, 15) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One APB write: setup cycle, then access cycle. The register takes the
  // value at the edge that closes the access, and so does the local copy.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_MODE:           ctl.mode                 = pid_mode_t'(val[0]);
      REG_GAIN_P:         ctl.gain_p               = val[GAIN_W-1:0];
      REG_GAIN_I:         ctl.gain_i               = val[GAIN_W-1:0];
      REG_GAIN_D:         ctl.gain_d               = val[GAIN_W-1:0];
      REG_DERIV_FILTER:   ctl.deriv_filter         = val[GAMMA_W-1:0];
      REG_INTEGRAL_LIMIT: ctl.integral_limit       = val[LIMIT_W-1:0];
      REG_OUTPUT_LIMIT:   ctl.output_limit         = val[LIMIT_W-1:0];
      REG_SEPARATION:     ctl.separation_threshold = val[SEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Offers one sample and returns at the edge where it is accepted. The
  // next negative edge either brings the following sample or lowers valid,
  // so a beat is never offered twice.
  task automatic send_sample(input logic [15:0] sp, input logic [15:0] fb,
                             input bit lit_on, input logic [15:0] lit);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 15);
    end
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {fb, sp};
    literal_q.push_back({lit_on, lit});
    do @(posedge clk); while (!in_tready);
  endtask

  // Drops valid, waits for every drive beat still due and lets the
  // sequencer settle, so that registers may be written.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic plan_row_t wr(input reg_idx_t idx, input int val);
    plan_row_t r;
    r = '{is_write: 1'b1, idx: idx, val: val, sp: '0, fb: '0, lit_on: 1'b0, lit: '0};
    return r;
  endfunction

  function automatic plan_row_t smp(input int sp, input int fb);
    plan_row_t r;
    r = '{is_write: 1'b0, idx: REG_MODE, val: '0, sp: sp[15:0], fb: fb[15:0],
          lit_on: 1'b0, lit: '0};
    return r;
  endfunction

  function automatic plan_row_t smp_lit(input int sp, input int fb, input int drive);
    plan_row_t r;
    r        = smp(sp, fb);
    r.lit_on = 1'b1;
    r.lit    = drive[15:0];
    return r;
  endfunction

  // Gains lean toward small values so that outputs do not simply saturate,
  // with the extremes and the full range mixed in.
  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 24'hFFFFFF;
      2:       return $urandom_range(0, 24'hFFFFFF);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic int unsigned pick_limit();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32767;
      2:       return $urandom_range(0, 32767);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  function automatic int unsigned pick_gamma();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65536;
      2:       return 131071;
      3:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic int unsigned pick_separation();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  // Every register is rewritten at the start of each random phase.
  task automatic load_random_settings();
    write_reg(REG_MODE, $urandom_range(0, 1));
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    write_reg(REG_DERIV_FILTER, pick_gamma());
    write_reg(REG_INTEGRAL_LIMIT, pick_limit());
    write_reg(REG_OUTPUT_LIMIT, pick_limit());
    write_reg(REG_SEPARATION, pick_separation());
  endtask

  // Most samples track: feedback anywhere, setpoint a short way off, so the
  // history and the integral build up without pinning the output. The rest
  // cover the whole range of both fields.
  task automatic send_random_sample();
    int fbv, spv;
    fbv = $signed(16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 9) < 7) begin
      spv = fbv + $signed($urandom_range(0, 1000)) - 500;
      if (spv > 32767) spv = 32767;
      if (spv < -32768) spv = -32768;
    end else begin
      spv = $signed(16'($urandom_range(0, 65535)));
    end
    send_sample(spv[15:0], fbv[15:0], 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int i, sent, phase, n;

    // Reset values of the registers and a cleared controller state.
    ctl = '{mode: MODE_POSITION, gain_p: '0, gain_i: '0, gain_d: '0, deriv_filter: '0,
            integral_limit: 15'h7FFF, output_limit: 15'h7FFF,
            separation_threshold: 16'hFFFF};
    err_last   = 0;
    err_last2  = 0;
    integ_sum  = 0;
    deriv_last = 0;
    drive_fx   = 0;

    plan = '{
      // Straight after reset every gain is zero, so even the largest error
      // gives no drive.
      smp_lit(32767, -32768, 0),
      smp_lit(-32768, 32767, 0),
      // Unity proportional gain: the drive is the error, saturated at the
      // output limit, symmetric about zero.
      wr(REG_GAIN_P, 32'h0001_0000),
      smp_lit(100, 0, 100),
      smp_lit(0, 100, -100),
      smp_lit(32767, -32768, 32767),
      smp_lit(-32768, 32767, -32767),
      wr(REG_OUTPUT_LIMIT, 0),
      smp_lit(32767, -32768, 0),
      wr(REG_OUTPUT_LIMIT, 32767),
      // Largest gain against the smallest error: the fraction is dropped
      // toward zero on both sides.
      wr(REG_GAIN_P, 32'h00FF_FFFF),
      smp_lit(1, 0, 255),
      smp_lit(0, 1, -255),
      // Integral on its own, clamped by its limit.
      wr(REG_GAIN_P, 0),
      wr(REG_GAIN_I, 32'h0001_0000),
      wr(REG_INTEGRAL_LIMIT, 50),
      smp_lit(30, 0, 30),
      smp_lit(30, 0, 50),
      // Integral separation: a large error leaves the integral out.
      wr(REG_SEPARATION, 10),
      smp_lit(30, 0, 0),
      smp(-5, 0),
      // A lowered integral limit bites on the next positional sample.
      wr(REG_INTEGRAL_LIMIT, 20),
      smp(0, 0),
      // Filtered derivative, then gamma above one.
      wr(REG_GAIN_D, 32'h0001_0000),
      wr(REG_DERIV_FILTER, 32768),
      smp(200, 0),
      smp(-300, 0),
      wr(REG_DERIV_FILTER, 131071),
      smp(1000, -1000),
      smp(-32768, 32767),
      // Switch to incremental mode, where the separation threshold has no
      // effect, and back again from the shared running output.
      wr(REG_MODE, 32'(MODE_DELTA)),
      wr(REG_SEPARATION, 0),
      smp(500, 0),
      smp(500, 0),
      smp(-32768, 32767),
      wr(REG_GAIN_P, 32'h0001_0000),
      smp(7, -7),
      wr(REG_MODE, 32'(MODE_POSITION)),
      smp(50, 25),
      smp(32767, 32767)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with moderate idling on both sides.
    gap_pct   = 20;
    stall_pct = 20;
    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].is_write) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].sp, plan[i].fb, plan[i].lit_on, plan[i].lit);
      end
    end

    // Random phases. Idling varies from phase to phase, including phases
    // without any; the closing phases run flat out.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      load_random_settings();
      calm = (sent >= RANDOM_ITEMS - 120);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 40;
      endcase
      if (phase == 2) begin
        sink_hold = LONG_HOLD;
      end
      n = $urandom_range(40, 80);
      repeat (n) send_random_sample();
      sent += n;
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("pid_position_delta_controller_unit regression: pass");
    end else begin
      $display("pid_position_delta_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
